/* rtl/modular_inverse_ext_euclid_defines.svh */
// Assertion macros for the modular inverse block.
`ifndef MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH
`define MODULAR_INVERSE_EXT_EUCLID_DEFINES_SVH

`ifndef ASSERT_OFF

`define MIE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define MIE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define MIE_ASSERT_IMP(lbl, ante, cons, msg)

`define MIE_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

/* rtl/mie_pkg.sv */
package mie_pkg;

    typedef logic [2:0] state_t;

    localparam state_t ST_IDLE  = 3'd0;
    localparam state_t ST_CHECK = 3'd1;
    localparam state_t ST_ALIGN = 3'd2;
    localparam state_t ST_DIV   = 3'd3;
    localparam state_t ST_ADD   = 3'd4;
    localparam state_t ST_COEF  = 3'd5;

endpackage

/* rtl/modular_inverse_ext_euclid.sv */
// Modular inverse by the extended Euclidean algorithm. Write the modulus through the
// cfg channel while busy and start are low; pulse start with value while busy is low. Each
// item yields one result, shown for a single cycle with done high; the receiver cannot
// stall it, so capture found, inverse and gcd_value on that cycle. One shared
// shift-subtract divider, a modular doubler, a modular adder and a modular subtractor do
// all work. Each Euclid step runs one check, divisor alignment, one restoring step per
// quotient bit and one coefficient update, with one modular add for each one bit in the
// quotient (none when the modulus is below two). A last check ends the item and the
// result shows on the cycle after it.
`include "modular_inverse_ext_euclid_defines.svh"

module modular_inverse_ext_euclid #(
    parameter int WIDTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [WIDTH-1:0] modulus,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] value,
    output logic             done,
    output logic             found,
    output logic [WIDTH-1:0] inverse,
    output logic [WIDTH-1:0] gcd_value
);

    localparam int KW = $clog2(WIDTH);

    mie_pkg::state_t  state_reg, state_next;
    logic [WIDTH-1:0] modulus_reg;
    logic             mod_ok_reg, mod_ok_next;
    logic [WIDTH-1:0] rp_reg, rp_next;
    logic [WIDTH-1:0] rc_reg, rc_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] d_reg, d_next;
    logic [KW-1:0]    k_reg, k_next;
    logic [WIDTH-1:0] cp_reg, cp_next;
    logic [WIDTH-1:0] cc_reg, cc_next;
    logic [WIDTH-1:0] acc_reg, acc_next;
    logic             done_reg, done_next;
    logic             found_reg, found_next;
    logic [WIDTH-1:0] inverse_reg, inverse_next;
    logic [WIDTH-1:0] gcd_reg, gcd_next;

    logic             align_ok;
    logic             div_ge;
    logic [WIDTH-1:0] rem_sub;
    logic [WIDTH:0]   dbl_sum;
    logic [WIDTH+1:0] dbl_red;
    logic [WIDTH-1:0] dbl_mod;
    logic [WIDTH:0]   add_sum;
    logic [WIDTH+1:0] add_red;
    logic [WIDTH-1:0] add_mod;
    logic [WIDTH:0]   sub_diff;
    logic [WIDTH-1:0] sub_mod;
    logic             div_phase;
    logic             coef_ok;

    assign busy      = (state_reg != mie_pkg::ST_IDLE);
    assign cfg_ready = ~busy & ~start;
    assign done      = done_reg;
    assign found     = found_reg;
    assign inverse   = inverse_reg;
    assign gcd_value = gcd_reg;

    // divider datapath
    assign align_ok = ({d_reg, 1'b0} <= {1'b0, rem_reg});
    assign div_ge   = (rem_reg >= d_reg);
    assign rem_sub  = rem_reg - d_reg;

    // modular double, modular add, modular subtract
    assign dbl_sum = {1'b0, acc_reg} + {1'b0, acc_reg};
    assign dbl_red = {1'b0, dbl_sum} - {2'b00, modulus_reg};
    assign dbl_mod = dbl_red[WIDTH+1] ? dbl_sum[WIDTH-1:0] : dbl_red[WIDTH-1:0];

    assign add_sum = {1'b0, acc_reg} + {1'b0, cc_reg};
    assign add_red = {1'b0, add_sum} - {2'b00, modulus_reg};
    assign add_mod = add_red[WIDTH+1] ? add_sum[WIDTH-1:0] : add_red[WIDTH-1:0];

    assign sub_diff = {1'b0, cp_reg} - {1'b0, acc_reg};
    assign sub_mod  = sub_diff[WIDTH] ? (sub_diff[WIDTH-1:0] + modulus_reg)
                                      : sub_diff[WIDTH-1:0];

    assign div_phase = (state_reg == mie_pkg::ST_DIV) || (state_reg == mie_pkg::ST_ADD);
    assign coef_ok   = (cc_reg < modulus_reg) && (acc_reg < modulus_reg);

    always_comb
    begin
        state_next   = state_reg;
        mod_ok_next  = mod_ok_reg;
        rp_next      = rp_reg;
        rc_next      = rc_reg;
        rem_next     = rem_reg;
        d_next       = d_reg;
        k_next       = k_reg;
        cp_next      = cp_reg;
        cc_next      = cc_reg;
        acc_next     = acc_reg;
        done_next    = 1'b0;
        found_next   = found_reg;
        inverse_next = inverse_reg;
        gcd_next     = gcd_reg;
        unique case (state_reg)
            mie_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    mod_ok_next = (modulus_reg > WIDTH'(1));
                    rp_next     = modulus_reg;
                    rc_next     = value;
                    cp_next     = '0;
                    cc_next     = (modulus_reg > WIDTH'(1)) ? WIDTH'(1) : '0;
                    acc_next    = '0;
                    state_next  = mie_pkg::ST_CHECK;
                end
            end
            mie_pkg::ST_CHECK:
            begin
                if (rc_reg > WIDTH'(1))
                begin
                    rem_next   = rp_reg;
                    d_next     = rc_reg;
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = mie_pkg::ST_ALIGN;
                end
                else
                begin
                    done_next    = 1'b1;
                    found_next   = (rc_reg == WIDTH'(1)) && mod_ok_reg;
                    inverse_next = ((rc_reg == WIDTH'(1)) && mod_ok_reg) ? cc_reg : '0;
                    gcd_next     = (rc_reg == WIDTH'(1)) ? WIDTH'(1) : rp_reg;
                    state_next   = mie_pkg::ST_IDLE;
                end
            end
            mie_pkg::ST_ALIGN:
            begin
                if (align_ok)
                begin
                    d_next = {d_reg[WIDTH-2:0], 1'b0};
                    k_next = k_reg + KW'(1);
                end
                else
                begin
                    state_next = mie_pkg::ST_DIV;
                end
            end
            mie_pkg::ST_DIV:
            begin
                if (div_ge)
                begin
                    rem_next = rem_sub;
                end
                acc_next = mod_ok_reg ? dbl_mod : '0;
                d_next   = {1'b0, d_reg[WIDTH-1:1]};
                if (div_ge && mod_ok_reg)
                begin
                    state_next = mie_pkg::ST_ADD;
                end
                else if (k_reg == '0)
                begin
                    state_next = mie_pkg::ST_COEF;
                end
                else
                begin
                    k_next = k_reg - KW'(1);
                end
            end
            mie_pkg::ST_ADD:
            begin
                acc_next = add_mod;
                if (k_reg == '0)
                begin
                    state_next = mie_pkg::ST_COEF;
                end
                else
                begin
                    k_next     = k_reg - KW'(1);
                    state_next = mie_pkg::ST_DIV;
                end
            end
            mie_pkg::ST_COEF:
            begin
                cp_next    = cc_reg;
                cc_next    = mod_ok_reg ? sub_mod : '0;
                rp_next    = rc_reg;
                rc_next    = rem_reg;
                state_next = mie_pkg::ST_CHECK;
            end
            default:
            begin
                state_next = mie_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= mie_pkg::ST_IDLE;
            modulus_reg <= WIDTH'(2);
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                modulus_reg <= modulus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mod_ok_reg  <= mod_ok_next;
        rp_reg      <= rp_next;
        rc_reg      <= rc_next;
        rem_reg     <= rem_next;
        d_reg       <= d_next;
        k_reg       <= k_next;
        cp_reg      <= cp_next;
        cc_reg      <= cc_next;
        acc_reg     <= acc_next;
        found_reg   <= found_next;
        inverse_reg <= inverse_next;
        gcd_reg     <= gcd_next;
    end

    `MIE_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
    `MIE_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted item did not start")
    `MIE_ASSERT_IMP(a_div_nonzero, div_phase, d_reg != '0, "divisor is zero")
    `MIE_ASSERT_IMP(a_coef_range, busy && mod_ok_reg, coef_ok, "coefficient not reduced")
    `MIE_ASSERT_IMP(a_found_gcd, done && found, gcd_value == WIDTH'(1), "inverse with gcd not one")

endmodule

/* tb/tb_modular_inverse_ext_euclid.sv */
module tb_modular_inverse_ext_euclid;

    localparam int WIDTH = 64;
    localparam logic [WIDTH-1:0] ALL_ONES  = {WIDTH{1'b1}};
    localparam logic [WIDTH-1:0] TOP_PRIME = 64'hFFFF_FFFF_FFFF_FFC5;
    localparam logic [WIDTH-1:0] MERSENNE  = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam logic [WIDTH-1:0] HALF_TOP  = 64'h8000_0000_0000_0000;
    localparam int PHASES           = 12;
    localparam int ITEMS_PER_PHASE  = 96;

    typedef enum logic { ROW_CFG, ROW_ITEM } row_kind_t;

    typedef struct {
        logic             found;
        logic [WIDTH-1:0] inverse;
        logic [WIDTH-1:0] gcd_value;
    } inv_result_t;

    typedef struct {
        row_kind_t        kind;
        logic [WIDTH-1:0] data;
        bit               typed;
        inv_result_t      res;
    } dir_row_t;

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [WIDTH-1:0] modulus   = '0;
    logic             start     = 1'b0;
    logic             busy;
    logic [WIDTH-1:0] value     = '0;
    logic             done;
    logic             found;
    logic [WIDTH-1:0] inverse;
    logic [WIDTH-1:0] gcd_value;

    logic [WIDTH-1:0] cur_modulus = 64'd2;
    inv_result_t      pending_results[$];
    dir_row_t         dir_rows[$];
    int               errors = 0;

    modular_inverse_ext_euclid #(
        .WIDTH(WIDTH)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .modulus   (modulus),
        .start     (start),
        .busy      (busy),
        .value     (value),
        .done      (done),
        .found     (found),
        .inverse   (inverse),
        .gcd_value (gcd_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("tb_modular_inverse_ext_euclid failed");
        $finish;
    end

    function automatic inv_result_t predict_inverse(input logic [WIDTH-1:0] m,
                                                    input logic [WIDTH-1:0] v);
        inv_result_t      r;
        logic [WIDTH-1:0] rem_a, rem_b, rem_n, quot;
        logic [WIDTH-1:0] coef_a, coef_b, coef_n;
        logic [2*WIDTH-1:0] prod;
        bit               mod_ok;
        mod_ok = (m >= 2);
        rem_a  = m;
        rem_b  = v;
        coef_a = '0;
        coef_b = mod_ok ? WIDTH'(1) : '0;
        while (rem_b > 1)
        begin
            quot   = rem_a / rem_b;
            rem_n  = rem_a % rem_b;
            coef_n = '0;
            if (mod_ok)
            begin
                prod = ({{WIDTH{1'b0}}, quot % m} * {{WIDTH{1'b0}}, coef_b})
                       % {{WIDTH{1'b0}}, m};
                if (coef_a >= prod[WIDTH-1:0])
                    coef_n = coef_a - prod[WIDTH-1:0];
                else
                    coef_n = coef_a + (m - prod[WIDTH-1:0]);
            end
            rem_a  = rem_b;
            rem_b  = rem_n;
            coef_a = coef_b;
            coef_b = coef_n;
        end
        if (rem_b == 1)
        begin
            r.found     = mod_ok;
            r.inverse   = mod_ok ? coef_b : '0;
            r.gcd_value = WIDTH'(1);
        end
        else
        begin
            r.found     = 1'b0;
            r.inverse   = '0;
            r.gcd_value = rem_a;
        end
        return r;
    endfunction

    function automatic logic [WIDTH-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WIDTH-1:0] pick_value(input logic [WIDTH-1:0] m);
        int unsigned      pick;
        logic [WIDTH-1:0] tiny;
        pick = $urandom_range(0, 9);
        tiny = WIDTH'($urandom_range(0, 300));
        case (pick)
            5:       return rand_word() % m;
            6:       return tiny;
            7:       return (m > tiny) ? m - tiny : rand_word();
            8:       return rand_word() << $urandom_range(0, 63);
            9:
            begin
                case ($urandom_range(0, 5))
                    0:       return '0;
                    1:       return WIDTH'(1);
                    2:       return m;
                    3:       return m - 1;
                    4:       return ALL_ONES;
                    default: return HALF_TOP;
                endcase
            end
            default: return rand_word();
        endcase
    endfunction

    function automatic logic [WIDTH-1:0] pick_modulus(input int phase);
        logic [WIDTH-1:0] m;
        case (phase)
            0:       m = 64'd2;
            1:       m = ALL_ONES;
            2:       m = TOP_PRIME;
            3:       m = 64'd3;
            4:       m = MERSENNE;
            5:       m = HALF_TOP;
            default:
            begin
                if (phase % 2 == 0)
                    m = rand_word() | 64'd1;
                else
                    m = rand_word() >> $urandom_range(0, 62);
            end
        endcase
        if (m < 2)
            m = 64'd2;
        return m;
    endfunction

    function automatic int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_modulus(input logic [WIDTH-1:0] m);
        while (pending_results.size() != 0 || busy)
            @(posedge clk);
        cfg_valid <= 1'b1;
        modulus   <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cur_modulus = m;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_value(input logic [WIDTH-1:0] v, input bit typed,
                              input inv_result_t typed_res);
        start <= 1'b1;
        value <= v;
        do
            @(posedge clk);
        while (busy);
        if (typed)
            pending_results.push_back(typed_res);
        else
            pending_results.push_back(predict_inverse(cur_modulus, v));
    endtask

    task automatic hold_gap(input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic add_row(input row_kind_t kind, input logic [WIDTH-1:0] data,
                           input bit typed, input logic f,
                           input logic [WIDTH-1:0] inv, input logic [WIDTH-1:0] g);
        dir_row_t row;
        row.kind          = kind;
        row.data          = data;
        row.typed         = typed;
        row.res.found     = f;
        row.res.inverse   = inv;
        row.res.gcd_value = g;
        dir_rows.push_back(row);
    endtask

    always @(posedge clk)
    begin
        inv_result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: found=%0d inverse=%0h gcd_value=%0h",
                       found, inverse, gcd_value);
                errors++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (found !== exp_res.found)
                begin
                    $error("found: expected %0d, actual %0d", exp_res.found, found);
                    errors++;
                end
                if (inverse !== exp_res.inverse)
                begin
                    $error("inverse: expected %0h, actual %0h", exp_res.inverse, inverse);
                    errors++;
                end
                if (gcd_value !== exp_res.gcd_value)
                begin
                    $error("gcd_value: expected %0h, actual %0h",
                           exp_res.gcd_value, gcd_value);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        logic [WIDTH-1:0] m;
        bit               no_idle;
        inv_result_t      none;
        none = '{found: 1'b0, inverse: '0, gcd_value: '0};

        add_row(ROW_ITEM, 64'd0,         1'b1, 1'b0, 64'd0,         64'd2);
        add_row(ROW_ITEM, 64'd1,         1'b1, 1'b1, 64'd1,         64'd1);
        add_row(ROW_ITEM, 64'd2,         1'b1, 1'b0, 64'd0,         64'd2);
        add_row(ROW_ITEM, ALL_ONES,      1'b1, 1'b1, 64'd1,         64'd1);
        add_row(ROW_CFG,  ALL_ONES,      1'b0, 1'b0, 64'd0,         64'd0);
        add_row(ROW_ITEM, 64'd0,         1'b1, 1'b0, 64'd0,         ALL_ONES);
        add_row(ROW_ITEM, 64'd1,         1'b1, 1'b1, 64'd1,         64'd1);
        add_row(ROW_ITEM, ALL_ONES,      1'b1, 1'b0, 64'd0,         ALL_ONES);
        add_row(ROW_ITEM, ALL_ONES - 1,  1'b1, 1'b1, ALL_ONES - 1,  64'd1);
        add_row(ROW_ITEM, 64'd3,         1'b1, 1'b0, 64'd0,         64'd3);
        add_row(ROW_ITEM, 64'd2,         1'b0, 1'b0, 64'd0,         64'd0);
        add_row(ROW_CFG,  TOP_PRIME,     1'b0, 1'b0, 64'd0,         64'd0);
        add_row(ROW_ITEM, 64'd1,         1'b1, 1'b1, 64'd1,         64'd1);
        add_row(ROW_ITEM, ALL_ONES,      1'b0, 1'b0, 64'd0,         64'd0);
        add_row(ROW_ITEM, 64'd0,         1'b1, 1'b0, 64'd0,         TOP_PRIME);
        add_row(ROW_ITEM, TOP_PRIME,     1'b1, 1'b0, 64'd0,         TOP_PRIME);
        add_row(ROW_ITEM, TOP_PRIME - 1, 1'b1, 1'b1, TOP_PRIME - 1, 64'd1);
        add_row(ROW_ITEM, HALF_TOP,      1'b0, 1'b0, 64'd0,         64'd0);
        add_row(ROW_ITEM, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 64'd0, 64'd0);
        add_row(ROW_ITEM, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 64'd0, 64'd0);
        add_row(ROW_CFG,  HALF_TOP,      1'b0, 1'b0, 64'd0,         64'd0);
        add_row(ROW_ITEM, 64'h4000_0000_0000_0000, 1'b0, 1'b0, 64'd0, 64'd0);
        add_row(ROW_ITEM, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'd0, 64'd0);
        add_row(ROW_CFG,  64'd3,         1'b0, 1'b0, 64'd0,         64'd0);
        add_row(ROW_ITEM, ALL_ONES,      1'b0, 1'b0, 64'd0,         64'd0);
        add_row(ROW_ITEM, 64'd5,         1'b0, 1'b0, 64'd0,         64'd0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].kind == ROW_CFG)
            begin
                start <= 1'b0;
                write_modulus(dir_rows[i].data);
            end
            else
            begin
                send_value(dir_rows[i].data, dir_rows[i].typed, dir_rows[i].res);
                hold_gap(pick_gap());
            end
        end

        for (int p = 0; p < PHASES; p++)
        begin
            start <= 1'b0;
            m = pick_modulus(p);
            write_modulus(m);
            no_idle = (p % 4 == 1);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_value(pick_value(cur_modulus), 1'b0, none);
                hold_gap(no_idle ? 0 : pick_gap());
            end
        end
        start <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (errors == 0)
            $display("tb_modular_inverse_ext_euclid passed");
        else
            $display("tb_modular_inverse_ext_euclid failed");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/mie_pkg.sv
rtl/modular_inverse_ext_euclid.sv
tb/tb_modular_inverse_ext_euclid.sv
